// ===== hdl/temp_probe_scratchpad_checker_assert.svh =====
// Assertion macros used by the checker file of the scratchpad checker.
`ifndef TEMP_PROBE_SCRATCHPAD_CHECKER_ASSERT_SVH
`define TEMP_PROBE_SCRATCHPAD_CHECKER_ASSERT_SVH

// Implication checked at every rising edge, muted while reset is high.
`define TPSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also evaluated while reset is high.
`define TPSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/tpsc_pkg.sv =====
// Shared types, constants and the CRC step for the scratchpad checker.
package tpsc_pkg;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_SENSOR = 3'd1;
  localparam logic [2:0] STAT_CRC       = 3'd2;
  localparam logic [2:0] STAT_STUCK_LOW = 3'd3;
  localparam logic [2:0] STAT_NO_RESP   = 3'd4;

  // Input command codes
  localparam logic CMD_NO_PRESENCE = 1'b0;
  localparam logic CMD_BYTE        = 1'b1;

  // Frame and conversion constants
  localparam logic [7:0]  CRC_POLY    = 8'h8C;
  localparam logic [7:0]  BYTE_ONES   = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic signed [16:0] F_OFFSET = 17'sd320;
  // floor(m / 5) == (m * RECIP5) >> RECIP5_SHIFT for m < 2**22
  localparam logic [19:0] RECIP5       = 20'd838861;
  localparam int          RECIP5_SHIFT = 22;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL9,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // input transaction this cycle
    logic scale_en;  // register celsius tenths
    logic mul9_en;   // register |c * 9| and its sign
    logic load_out;  // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_result;  // current input item closes a frame or reports no presence
  } dp_status_t;

  // One byte of reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ b[k];
      c = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/tpsc_ctrl.sv =====
// Controller state machine: input handshake, conversion sequencing, output valid.
module tpsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tpsc_pkg::dp_status_t  dp_status,
  output tpsc_pkg::ctrl_cmd_t   ctrl_cmd
);

  tpsc_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  // State register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpsc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpsc_pkg::ST_IDLE: begin
        if (in_valid && dp_status.has_result) begin
          state_next = tpsc_pkg::ST_SCALE;
        end
      end
      tpsc_pkg::ST_SCALE: state_next = tpsc_pkg::ST_MUL9;
      tpsc_pkg::ST_MUL9:  state_next = tpsc_pkg::ST_OUT;
      tpsc_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = tpsc_pkg::ST_IDLE;
        end
      end
      default: state_next = tpsc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall          = (state != tpsc_pkg::ST_IDLE);
    ctrl_cmd.take     = in_valid && (state == tpsc_pkg::ST_IDLE);
    ctrl_cmd.scale_en = (state == tpsc_pkg::ST_SCALE);
    ctrl_cmd.mul9_en  = (state == tpsc_pkg::ST_MUL9);
    ctrl_cmd.load_out = (state == tpsc_pkg::ST_OUT) && out_free;
    out_valid_next    = ctrl_cmd.load_out || (out_valid && out_stall);
  end

endmodule

// ===== hdl/tpsc_datapath.sv =====
// Datapath: frame accumulators, frame judgement, temperature conversion, output register.
module tpsc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd,
  input  logic [7:0]            data_byte,
  input  tpsc_pkg::ctrl_cmd_t   ctrl_cmd,
  output tpsc_pkg::dp_status_t  dp_status,
  output logic [2:0]            status,
  output logic signed [15:0]    raw_temp,
  output logic signed [15:0]    celsius_tenths,
  output logic signed [16:0]    fahrenheit_tenths
);

  // Frame state
  logic [3:0] byte_count;
  logic [7:0] crc_reg;
  logic [7:0] and_acc;
  logic [7:0] or_acc;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_high_byte;

  // Conversion pipeline
  logic [2:0]          stat_r;
  logic signed [15:0]  raw_r;
  logic signed [15:0]  c10_r;
  logic [17:0]         mag_r;
  logic                neg_r;

  logic                last_byte;
  logic [7:0]          all_and;
  logic [7:0]          all_or;
  logic [2:0]          frame_stat;
  logic signed [19:0]  raw_x10;
  logic signed [19:0]  raw_x10_adj;
  logic signed [19:0]  c_x9;
  logic [19:0]         c_x9_abs;
  logic [37:0]         q_prod;
  logic [15:0]         q;
  logic signed [16:0]  q_signed;

  assign last_byte            = byte_count[3];
  assign dp_status.has_result = (cmd == tpsc_pkg::CMD_NO_PRESENCE) || last_byte;

  // Judge the frame on its ninth byte
  assign all_and = and_acc & data_byte;
  assign all_or  = or_acc | data_byte;
  always_comb begin
    priority if (all_or == tpsc_pkg::BYTE_ZERO) begin
      frame_stat = tpsc_pkg::STAT_STUCK_LOW;
    end else if (all_and == tpsc_pkg::BYTE_ONES) begin
      frame_stat = tpsc_pkg::STAT_NO_RESP;
    end else if (crc_reg != data_byte) begin
      frame_stat = tpsc_pkg::STAT_CRC;
    end else begin
      frame_stat = tpsc_pkg::STAT_OK;
    end
  end

  // Frame accumulators; cleared on reset, at frame end and on presence failure
  always_ff @(posedge clk) begin
    if (rst || (ctrl_cmd.take && dp_status.has_result)) begin
      byte_count     <= 4'd0;
      crc_reg        <= tpsc_pkg::BYTE_ZERO;
      and_acc        <= tpsc_pkg::BYTE_ONES;
      or_acc         <= tpsc_pkg::BYTE_ZERO;
      temp_low_byte  <= tpsc_pkg::BYTE_ZERO;
      temp_high_byte <= tpsc_pkg::BYTE_ZERO;
    end else if (ctrl_cmd.take) begin
      byte_count <= byte_count + 4'd1;
      crc_reg    <= tpsc_pkg::crc8_byte(crc_reg, data_byte);
      and_acc    <= and_acc & data_byte;
      or_acc     <= or_acc | data_byte;
      if (byte_count == 4'd0) begin
        temp_low_byte <= data_byte;
      end
      if (byte_count == 4'd1) begin
        temp_high_byte <= data_byte;
      end
    end
  end

  // Capture status and raw value; a zero raw value yields the error fields
  always_ff @(posedge clk) begin
    if (ctrl_cmd.take && dp_status.has_result) begin
      if (cmd == tpsc_pkg::CMD_NO_PRESENCE) begin
        stat_r <= tpsc_pkg::STAT_NO_SENSOR;
        raw_r  <= 16'sd0;
      end else begin
        stat_r <= frame_stat;
        raw_r  <= (frame_stat == tpsc_pkg::STAT_OK) ?
                  $signed({temp_high_byte, temp_low_byte}) : 16'sd0;
      end
    end
  end

  // Celsius tenths: raw * 10 / 16, truncated toward zero
  assign raw_x10     = (20'(raw_r) <<< 3) + (20'(raw_r) <<< 1);
  assign raw_x10_adj = raw_x10 + (raw_x10[19] ? 20'sd15 : 20'sd0);

  // c * 9 split into magnitude and sign for the divide by five
  assign c_x9     = (20'(c10_r) <<< 3) + 20'(c10_r);
  assign c_x9_abs = c_x9[19] ? 20'(-c_x9) : c_x9;

  always_ff @(posedge clk) begin
    if (ctrl_cmd.scale_en) begin
      c10_r <= raw_x10_adj[19:4];
    end
    if (ctrl_cmd.mul9_en) begin
      mag_r <= c_x9_abs[17:0];
      neg_r <= c_x9[19];
    end
  end

  // Divide by five through the reciprocal, restore sign, add the offset
  assign q_prod   = 38'(mag_r) * 38'(tpsc_pkg::RECIP5);
  assign q        = q_prod[tpsc_pkg::RECIP5_SHIFT +: 16];
  assign q_signed = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});

  // Output register
  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_out) begin
      status            <= stat_r;
      raw_temp          <= raw_r;
      celsius_tenths    <= c10_r;
      fahrenheit_tenths <= q_signed + tpsc_pkg::F_OFFSET;
    end
  end

endmodule

// ===== hdl/temp_probe_scratchpad_checker.sv =====
// A ninth-byte or presence-failure transaction steps the controller through ST_SCALE,
// ST_MUL9 and ST_OUT before out_valid is set. Bytes 0 to 7 of a frame are taken one per
// cycle while idle; after a result item the input stalls in the conversion sequencer,
// longer while the output stalls. A waiting result does not block further data bytes.
// Reset (rst, synchronous) clears the frame accumulators and the controller at once.
// Top level: controller plus datapath of the scratchpad checker.
module temp_probe_scratchpad_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic signed [15:0]  raw_temp,
  output logic signed [15:0]  celsius_tenths,
  output logic signed [16:0]  fahrenheit_tenths
);

  tpsc_pkg::ctrl_cmd_t  ctrl_cmd;
  tpsc_pkg::dp_status_t dp_status;

  tpsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  tpsc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .data_byte         (data_byte),
    .ctrl_cmd          (ctrl_cmd),
    .dp_status         (dp_status),
    .status            (status),
    .raw_temp          (raw_temp),
    .celsius_tenths    (celsius_tenths),
    .fahrenheit_tenths (fahrenheit_tenths)
  );

endmodule

// ===== hdl/tpsc_checker.sv =====
// Port-level checker for the scratchpad checker, bound to the top level.
`include "temp_probe_scratchpad_checker_assert.svh"

module tpsc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                cmd,
  input logic                out_valid,
  input logic                out_stall,
  input logic [2:0]          status,
  input logic signed [15:0]  raw_temp,
  input logic signed [15:0]  celsius_tenths,
  input logic signed [16:0]  fahrenheit_tenths
);

  // A stalled result transaction holds its payload
  `TPSC_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(fahrenheit_tenths),
    "stalled result changed")

  // Any error status carries the fixed error fields
  `TPSC_ASSERT(a_err_fields,
    out_valid && (status != tpsc_pkg::STAT_OK) |-> (raw_temp == 16'sd0) &&
      (celsius_tenths == 16'sd0) && (fahrenheit_tenths == tpsc_pkg::F_OFFSET),
    "error result with nonzero fields")

  // A presence failure puts the block into conversion, so input stalls next cycle
  `TPSC_ASSERT(a_nosensor_busy,
    in_valid && !in_stall && (cmd == tpsc_pkg::CMD_NO_PRESENCE) |=> in_stall,
    "input not stalled after presence failure")

  // Status codes stay inside the defined set
  `TPSC_ASSERT(a_status_range, out_valid |-> (status <= tpsc_pkg::STAT_NO_RESP), "undefined status code")

  // The input side is open right after reset
  `TPSC_ASSERT_ALWAYS(a_reset_open, $past(rst) |-> !in_stall && !out_valid, "block busy after reset")

endmodule

bind temp_probe_scratchpad_checker tpsc_checker u_tpsc_checker (.*);

// ===== test/tb_temp_probe_scratchpad_checker.sv =====
// Testbench for the probe scratchpad checker: frame stimulus, reading predictor, result check.
`timescale 1ns / 1ps

module tb_temp_probe_scratchpad_checker;
  import tpsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEM_TARGET  = 1800;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PERCENT = 23;
  localparam int TAIL_CYCLES  = 20;

  // One expected converter reading
  typedef struct {
    logic [2:0]         status;
    logic signed [15:0] raw;
    logic signed [15:0] c10;
    logic signed [16:0] f10;
  } reading_t;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_ZERO, FR_ONES, FR_CUT} frame_kind_t;

  // Tracks frame state, predicts readings and matches them against the block
  class probe_reading_board;
    reading_t   readings_due[$];
    int         errors;
    logic [3:0] frame_pos;
    logic [7:0] crc_run;
    logic [7:0] and_run;
    logic [7:0] or_run;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_pos = 4'd0;
      crc_run   = 8'h00;
      and_run   = BYTE_ONES;
      or_run    = BYTE_ZERO;
      lo_byte   = 8'h00;
      hi_byte   = 8'h00;
    endfunction

    // Reflected CRC-8, data shifted in LSB first
    static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] bits;
      acc  = crc;
      bits = b;
      repeat (8) begin
        if (acc[0] ^ bits[0]) acc = (acc >> 1) ^ 8'h8C;
        else acc = acc >> 1;
        bits = bits >> 1;
      end
      return acc;
    endfunction

    function void push_error(logic [2:0] st);
      reading_t r;
      r.status = st;
      r.raw    = '0;
      r.c10    = '0;
      r.f10    = F_OFFSET;
      readings_due.push_back(r);
    endfunction

    // Note one accepted input transaction
    function void take_byte(logic c, logic [7:0] b);
      reading_t   r;
      int         raw_i;
      int         c_i;
      int         f_i;
      logic [7:0] all_and;
      logic [7:0] all_or;
      if (c == CMD_NO_PRESENCE) begin
        push_error(STAT_NO_SENSOR);
        clear_frame();
        return;
      end
      if (frame_pos < 4'd8) begin
        crc_run = crc_step(crc_run, b);
        and_run = and_run & b;
        or_run  = or_run | b;
        if (frame_pos == 4'd0) lo_byte = b;
        else if (frame_pos == 4'd1) hi_byte = b;
        frame_pos = frame_pos + 4'd1;
        return;
      end
      // CRC byte closes the frame
      all_and = and_run & b;
      all_or  = or_run | b;
      if (all_or == BYTE_ZERO) begin
        push_error(STAT_STUCK_LOW);
      end else if (all_and == BYTE_ONES) begin
        push_error(STAT_NO_RESP);
      end else if (crc_run != b) begin
        push_error(STAT_CRC);
      end else begin
        raw_i = int'($signed({hi_byte, lo_byte}));
        c_i = (raw_i * 10) / 16;         // truncates toward zero
        f_i = (c_i * 9) / 5 + int'(F_OFFSET);
        r.status = STAT_OK;
        r.raw    = raw_i[15:0];
        r.c10    = c_i[15:0];
        r.f10    = f_i[16:0];
        readings_due.push_back(r);
      end
      clear_frame();
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("[%0t] reading mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Compare one accepted result transaction with the oldest prediction
    task match_reading(logic [2:0] st, logic signed [15:0] raw,
                       logic signed [15:0] c10, logic signed [16:0] f10);
      reading_t r;
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("result status %0d with nothing due", st));
        return;
      end
      r = readings_due.pop_front();
      if (st !== r.status)
        report_mismatch($sformatf("status got %0d want %0d", st, r.status));
      if (raw !== r.raw)
        report_mismatch($sformatf("raw_temp got %0d want %0d", raw, r.raw));
      if (c10 !== r.c10)
        report_mismatch($sformatf("celsius_tenths got %0d want %0d", c10, r.c10));
      if (f10 !== r.f10)
        report_mismatch($sformatf("fahrenheit_tenths got %0d want %0d", f10, r.f10));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [7:0]         data_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic signed [15:0] raw_temp;
  logic signed [15:0] celsius_tenths;
  logic signed [16:0] fahrenheit_tenths;

  probe_reading_board board;
  int                 items_sent;
  int                 cycle_count;
  logic               calm;
  logic               hold_req;
  int                 hold_left;

  temp_probe_scratchpad_checker DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .cmd               (cmd),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .raw_temp          (raw_temp),
    .celsius_tenths    (celsius_tenths),
    .fahrenheit_tenths (fahrenheit_tenths)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, wait for its transaction, leave valid up for the next one
  task automatic send_item(logic c, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid  = 1'b0;
      cmd       = 1'($urandom);
      data_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid  = 1'b1;
    cmd       = c;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    board.take_byte(c, b);
    items_sent++;
    if (items_sent == 500 || items_sent == 1300) hold_req = 1'b1;
    if (items_sent == 800) calm = 1'b1;
    if (items_sent == 1100) calm = 1'b0;
    @(negedge clk);
  endtask

  // Nine-byte scratchpad frame, or a frame cut short by a presence failure
  task automatic send_frame(frame_kind_t kind, logic [15:0] raw, int cut_len);
    logic [7:0] fb [9];
    logic [7:0] crc;
    crc = 8'h00;
    fb[0] = raw[7:0];
    fb[1] = raw[15:8];
    for (int i = 2; i < 8; i++) fb[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) crc = probe_reading_board::crc_step(crc, fb[i]);
    fb[8] = (kind == FR_BAD_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc;
    if (kind == FR_ZERO) foreach (fb[i]) fb[i] = BYTE_ZERO;
    if (kind == FR_ONES) foreach (fb[i]) fb[i] = BYTE_ONES;
    if (kind == FR_CUT) begin
      for (int i = 0; i < cut_len; i++) send_item(CMD_BYTE, fb[i]);
      send_item(CMD_NO_PRESENCE, 8'($urandom));
    end else begin
      for (int i = 0; i < 9; i++) send_item(CMD_BYTE, fb[i]);
    end
  endtask

  function automatic logic [15:0] pick_raw();
    logic [15:0] corners [8] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
                                 16'h07D0, 16'hFC90, 16'h0001, 16'hFFF8};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  // Result side: random stalls plus long hold-offs on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.match_reading(status, raw_temp, celsius_tenths, fahrenheit_tenths);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_temp_probe_scratchpad_checker NOT OK");
    $finish;
  end

  // Main stimulus
  initial begin
    int pick;
    int burst;
    board      = new();
    items_sent = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_BYTE;
    data_byte  = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: lone presence failure, most negative reading, cut frame, silent bus
    send_item(CMD_NO_PRESENCE, 8'hA5);
    send_frame(FR_GOOD, 16'h8000, 0);
    send_frame(FR_CUT, 16'h0550, 3);
    send_frame(FR_ONES, 16'hFFFF, 0);

    // Random: mostly whole frames, some broken ones and noise
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        // finish any frame left open by noise so the next one lines up
        while (board.frame_pos != 4'd0) send_item(CMD_BYTE, 8'($urandom));
      end
      if (pick < 55) send_frame(FR_GOOD, pick_raw(), 0);
      else if (pick < 67) send_frame(FR_BAD_CRC, pick_raw(), 0);
      else if (pick < 72) send_frame(FR_ZERO, 16'h0000, 0);
      else if (pick < 77) send_frame(FR_ONES, 16'hFFFF, 0);
      else if (pick < 88) send_frame(FR_CUT, pick_raw(), $urandom_range(0, 8));
      else begin
        burst = $urandom_range(1, 6);
        repeat (burst)
          send_item(($urandom_range(0, 9) == 0) ? CMD_NO_PRESENCE : CMD_BYTE,
                    8'($urandom));
      end
    end
    in_valid = 1'b0;

    // Drain, then allow the pipeline latency to pass
    while (board.readings_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.readings_due.size() == 0) begin
      $display("tb_temp_probe_scratchpad_checker OK");
    end else begin
      $display("tb_temp_probe_scratchpad_checker NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tpsc_pkg.sv
hdl/tpsc_ctrl.sv
hdl/tpsc_datapath.sv
hdl/temp_probe_scratchpad_checker.sv
hdl/tpsc_checker.sv
test/tb_temp_probe_scratchpad_checker.sv
